// File: hw/rtl/lgs_pkg.sv
// Shared types and constants for the life grid generation step block.
package lgs_pkg;

	localparam int ROW_W        = 64;
	localparam int REQ_W        = 2;
	localparam int IDX_IN_W     = 4;
	localparam int ROWS_CFG_W   = 5;
	localparam int COLS_CFG_W   = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;
	localparam int DEF_MAX_ROWS = 16;
	localparam int DEF_MAX_COLS = 64;
	localparam int NBR_W        = 4;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET  = 5'd11;
	localparam logic [COLS_CFG_W-1:0] COLS_RESET  = 7'd38;

	// B3/S23: birth on three neighbors, survival on two or three
	localparam logic [NBR_W-1:0] BIRTH_CNT   = 4'd3;
	localparam logic [NBR_W-1:0] SURVIVE_CNT = 4'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE   = 2'd0,
		REQ_ADVANCE = 2'd1,
		REQ_READ    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic sweep_en;
		logic load_out;
	} ctrl_t;

endpackage

// File: hw/rtl/lgs_row_cell.sv
// One board row held in the rotating row chain.
module lgs_row_cell
	import lgs_pkg::*;
#(
	parameter int W = DEF_MAX_COLS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] row_q;

	// take the neighbor's row on every sweep cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift) begin
			row_q <= d;
		end
	end

	assign q = row_q;

endmodule

// File: hw/rtl/lgs_rule.sv
// B3/S23 next-row logic: one lane per column over a three-row window.
module lgs_rule
	import lgs_pkg::*;
#(
	parameter int W = DEF_MAX_COLS
) (
	input  logic [W-1:0] above,
	input  logic [W-1:0] here,
	input  logic [W-1:0] below,
	output logic [W-1:0] nxt
);

	logic [W+1:0] ap, hp, bp;

	// pad with dead cells so the edges do not wrap
	assign ap = {1'b0, above, 1'b0};
	assign hp = {1'b0, here, 1'b0};
	assign bp = {1'b0, below, 1'b0};

	for (genvar j = 0; j < W; j++) begin : g_col
		logic [NBR_W-1:0] n;
		assign n = NBR_W'(ap[j]) + NBR_W'(ap[j+1]) + NBR_W'(ap[j+2])
		         + NBR_W'(hp[j]) + NBR_W'(hp[j+2])
		         + NBR_W'(bp[j]) + NBR_W'(bp[j+1]) + NBR_W'(bp[j+2]);
		assign nxt[j] = (n == BIRTH_CNT) || (here[j] && (n == SURVIVE_CNT));
	end

endmodule

// File: hw/rtl/life_grid_generation_step.sv
// Top level of the life grid generation step block: control, row chain and result register.
//
// Usage:
//   The board is a chain of MAX_ROWS row cells, MAX_COLS cells wide, all dead after reset.
//   Requests arrive on in_valid/in_ready with req_type, row_index and row_bits:
//   write one row, read one row, or advance one B3/S23 generation (edges count as dead).
//   Every request rotates the whole chain once, one row per cycle past the head cell,
//   where the rule logic sees the row just before, the head row and the next one.
//   A write or read acts when its row passes the head; an advance rewrites every
//   row in use as it passes.
//   Sequence: the word is accepted in idle, the sweep passes every row past the head,
//   then the hand-off state loads the result register and out_valid rises.
//   A new request is taken only in idle, once the rotation and hand-off of the last end.
//   One result word per request on out_valid/out_ready: row_data and index_error.
//   The result sits in an output register; the next request is accepted while it
//   waits. If the receiver stalls, the following result holds in the hand-off state.
//   Configuration (cfg_valid/cfg_ready, always ready): index 0 rows_in_use,
//   index 1 cols_in_use, other indexes dropped. Write only while idle.
//   Reset (arst_n low) clears the board, the control and sets rows 11, cols 38.
module life_grid_generation_step
	import lgs_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [IDX_IN_W-1:0]   row_index,
	input  logic [ROW_W-1:0]      row_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ROW_W-1:0]      row_data,
	output logic                  index_error
);

	localparam int IDX_W = $clog2(MAX_ROWS);
	localparam int CNT_W = $clog2(MAX_ROWS + 1);
	localparam int RW    = (CNT_W > ROWS_CFG_W) ? CNT_W : ROWS_CFG_W;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ROWS - 1);

	// configuration registers
	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;

	// request held for the sweep
	req_t                 req_q;
	logic [IDX_IN_W-1:0]  idx_q;
	logic [MAX_COLS-1:0]  bits_q;
	logic                 err_q;
	logic [MAX_COLS-1:0]  rdata_q;
	logic [MAX_COLS-1:0]  prev_q;
	logic [IDX_W-1:0]     step_q;

	// output register
	logic                 out_valid_q;
	logic [ROW_W-1:0]     out_data_q;
	logic                 out_err_q;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [RW-1:0]          eff_rows;
	logic [COLS_CFG_W-1:0]  eff_cols;
	logic [MAX_COLS-1:0]    mask;
	logic                   in_acc;
	logic                   idx_ok;
	logic                   row_live;
	logic                   below_live;
	logic                   hit;
	logic [MAX_COLS-1:0]    head;
	logic [MAX_COLS-1:0]    second;
	logic [MAX_COLS-1:0]    above_m;
	logic [MAX_COLS-1:0]    below_m;
	logic [MAX_COLS-1:0]    rule_out;
	logic [MAX_COLS-1:0]    new_head;
	logic [MAX_COLS-1:0]    chain [MAX_ROWS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROWS: rows_q <= cfg_data[ROWS_CFG_W-1:0];
				CFG_COLS: cols_q <= cfg_data[COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective board size and column mask
	assign eff_rows = (RW'(rows_q) < RW'(MAX_ROWS)) ? RW'(rows_q) : RW'(MAX_ROWS);
	assign eff_cols = (cols_q < COLS_CFG_W'(MAX_COLS)) ? cols_q : COLS_CFG_W'(MAX_COLS);

	for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
		assign mask[j] = COLS_CFG_W'(j) < eff_cols;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SWEEP;
			ST_SWEEP: if (step_q == LAST_STEP) state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_SWEEP: ctrl.sweep_en = 1'b1;
			ST_DONE:  ctrl.load_out = !out_valid_q || out_ready;
			default:  ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.sweep_en) begin
				step_q <= (step_q == LAST_STEP) ? '0 : step_q + IDX_W'(1);
			end
		end
	end

	assign in_ready = ctrl.in_ready;
	assign in_acc   = in_valid && in_ready;
	assign idx_ok   = RW'(row_index) < eff_rows;

	// latch the request word; reads start from zero and fill on a hit
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q   <= req_t'(req_type);
			idx_q   <= row_index;
			bits_q  <= row_bits[MAX_COLS-1:0] & mask;
			err_q   <= !idx_ok && ((req_t'(req_type) == REQ_WRITE)
			                    || (req_t'(req_type) == REQ_READ));
			rdata_q <= '0;
		end else if (ctrl.sweep_en) begin
			prev_q <= head;
			if (req_q == REQ_READ && hit) begin
				rdata_q <= head & mask;
			end
		end
	end

	// head of the chain: row step_q of the board as it was before this sweep
	assign head       = chain[0];
	assign second     = chain[1];
	assign row_live   = RW'(step_q) < eff_rows;
	assign below_live = (RW'(step_q) + RW'(1)) < eff_rows;
	assign hit        = !err_q && (RW'(step_q) == RW'(idx_q));
	assign above_m    = (step_q != '0) ? (prev_q & mask) : '0;
	assign below_m    = below_live ? (second & mask) : '0;

	lgs_rule #(
		.W(MAX_COLS)
	) u_rule (
		.above (above_m),
		.here  (head & mask),
		.below (below_m),
		.nxt   (rule_out)
	);

	always_comb begin
		new_head = head;
		case (req_q)
			REQ_ADVANCE: if (row_live) new_head = rule_out & mask;
			REQ_WRITE:   if (hit) new_head = bits_q;
			default:     new_head = head;
		endcase
	end

	// rotate: each cell takes its upper neighbor, the tail takes the processed head
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		lgs_row_cell #(
			.W(MAX_COLS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ctrl.sweep_en),
			.d      ((i == MAX_ROWS - 1) ? new_head : chain[(i + 1) % MAX_ROWS]),
			.q      (chain[i])
		);
	end

	// result register: load from the hand-off state, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			out_data_q <= ROW_W'(rdata_q);
			out_err_q  <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign row_data    = out_data_q;
	assign index_error = out_err_q;

	// the step counter runs only inside a sweep
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SWEEP) |-> (step_q == '0))
		else $error("step counter moved outside a sweep");

	// a sweep ends only after the last row has passed the head
	a_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && $past(state_q) == ST_SWEEP) |-> ($past(step_q) == LAST_STEP))
		else $error("sweep ended early");

	// a new result appears only from the hand-off state
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside hand-off");

	// a flagged index never carries row contents
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_data_q == '0))
		else $error("index error with nonzero row data");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the life grid block: a directed table, then random board sizes.
`timescale 1ns / 1ps

module tb_top;
	import lgs_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 5;
	localparam int ITEM_TARGET = 1500;
	// Slowest item: the longest sender gap, a full sweep, the longest receiver stall.
	// Allow about 2500 items at that pace, then double it.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYC  = DEF_MAX_ROWS + 6;
	localparam int DIR_N       = 25;
	localparam int REPORT_MAX  = 10;

	// One result word: read data and the bad row flag.
	typedef struct packed {
		logic [ROW_W-1:0] data;
		logic             err;
	} row_result_t;

	// One row of the directed table; typed rows carry their own result.
	typedef struct packed {
		req_t              req;
		logic [IDX_IN_W-1:0] idx;
		logic [ROW_W-1:0]  bits;
		logic              typed;
		logic [ROW_W-1:0]  data;
		logic              err;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type;
	logic [IDX_IN_W-1:0]   row_index;
	logic [ROW_W-1:0]      row_bits;
	logic                  out_valid;
	logic                  out_ready;
	logic [ROW_W-1:0]      row_data;
	logic                  index_error;

	// Shadow of the block: board rows and both size registers.
	logic [ROW_W-1:0]      life_board [DEF_MAX_ROWS];
	logic [ROWS_CFG_W-1:0] rows_cfg;
	logic [COLS_CFG_W-1:0] cols_cfg;

	// Results still owed by the block, oldest first.
	row_result_t pending_results [$];

	dir_row_t dir_tab [DIR_N];

	int  cycle_cnt;
	int  mismatches;
	int  results_checked;
	int  items_sent;
	int  n_write, n_read, n_adv, n_none, n_bad, n_cfg;
	int  stall_left;
	bit  no_idle;

	life_grid_generation_step dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row_data    (row_data),
		.index_error (index_error)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------
	// Board predictor
	// ---------------------------------------------------------------

	// Rows taking part, clamped to the board height.
	function automatic int eff_row_count();
		return (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_cfg);
	endfunction

	// Columns taking part as a bit mask, clamped to the board width.
	function automatic logic [ROW_W-1:0] live_mask();
		int c;
		c = (cols_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_cfg);
		if (c >= ROW_W)
			return '1;
		return (64'd1 << c) - 64'd1;
	endfunction

	// Cell k of a row, dead off either end.
	function automatic int cell_bit(logic [ROW_W-1:0] row, int k);
		if (k < 0 || k >= ROW_W)
			return 0;
		return int'(row[k]);
	endfunction

	// Advance every row in use by one B3/S23 generation; rows past the count stay.
	function automatic void step_generation();
		logic [ROW_W-1:0] nxt [DEF_MAX_ROWS];
		logic [ROW_W-1:0] m, above, here, below;
		int r, n;
		r = eff_row_count();
		m = live_mask();
		for (int i = 0; i < DEF_MAX_ROWS; i++)
			nxt[i] = life_board[i];
		for (int i = 0; i < r; i++) begin
			above = (i > 0) ? (life_board[i-1] & m) : '0;
			here  = life_board[i] & m;
			below = (i + 1 < r) ? (life_board[i+1] & m) : '0;
			nxt[i] = '0;
			for (int j = 0; j < ROW_W; j++) begin
				n = 0;
				for (int d = -1; d <= 1; d++)
					n += cell_bit(above, j + d) + cell_bit(here, j + d)
					   + cell_bit(below, j + d);
				n -= int'(here[j]);
				if (here[j])
					nxt[i][j] = (n == int'(SURVIVE_CNT)) || (n == int'(BIRTH_CNT));
				else
					nxt[i][j] = (n == int'(BIRTH_CNT));
			end
			nxt[i] &= m;
		end
		for (int i = 0; i < DEF_MAX_ROWS; i++)
			life_board[i] = nxt[i];
	endfunction

	// Apply one request to the shadow board and return the word it should produce.
	function automatic row_result_t board_request(req_t req, logic [IDX_IN_W-1:0] idx,
			logic [ROW_W-1:0] bits);
		row_result_t res;
		res = '0;
		case (req)
			REQ_ADVANCE: step_generation();
			REQ_WRITE, REQ_READ: begin
				if (int'(idx) >= eff_row_count())
					res.err = 1'b1;
				else if (req == REQ_WRITE)
					life_board[idx] = bits & live_mask();
				else
					res.data = life_board[idx] & live_mask();
			end
			default: ;
		endcase
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Random helpers
	// ---------------------------------------------------------------

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Row contents of mixed density, so boards both crowd and thin out.
	function automatic logic [ROW_W-1:0] random_row();
		logic [ROW_W-1:0] a, b, c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return a;
			1: return a & b;
			2: return a & b & c;
			3: return a | b;
			4: return 64'(3'($urandom_range(1, 7))) << $urandom_range(0, 61);
			default: return ($urandom_range(0, 1) != 0) ? '1 : a & b & c & {$urandom, $urandom};
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// Send one request word and log its result; enter and leave at a falling edge.
	task automatic send_req(req_t req, logic [IDX_IN_W-1:0] idx, logic [ROW_W-1:0] bits,
			logic typed, row_result_t typed_res);
		int gap;
		row_result_t res;
		gap = no_idle ? 0 : gap_len();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		req_type  = req;
		row_index = idx;
		row_bits  = bits;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		res = board_request(req, idx, bits);
		pending_results.push_back(typed ? typed_res : res);
		items_sent++;
		case (req)
			REQ_WRITE:   n_write++;
			REQ_READ:    n_read++;
			REQ_ADVANCE: n_adv++;
			default:     n_none++;
		endcase
		if (res.err)
			n_bad++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Hold the sender until every owed word is back, then let the sweep settle.
	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_cfg(cfg_reg_t reg_idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = reg_idx;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (reg_idx == CFG_ROWS)
			rows_cfg = value[ROWS_CFG_W-1:0];
		else
			cols_cfg = value[COLS_CFG_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Resize the board; only ever done with the block idle.
	task automatic set_board_size(int rows, int cols);
		drain();
		put_cfg(CFG_ROWS, CFG_DATA_W'(rows));
		put_cfg(CFG_COLS, CFG_DATA_W'(cols));
		n_cfg++;
	endtask

	// Pick a row: mostly one in use, sometimes any index so bad rows show up.
	function automatic logic [IDX_IN_W-1:0] pick_row();
		if ($urandom_range(0, 4) != 0)
			return IDX_IN_W'($urandom_range(0, eff_row_count() - 1));
		return IDX_IN_W'($urandom_range(0, 15));
	endfunction

	// Loose single request of any kind.
	task automatic random_request();
		req_t req;
		int p;
		p = $urandom_range(0, 99);
		if (p < 30)
			req = REQ_WRITE;
		else if (p < 65)
			req = REQ_READ;
		else if (p < 90)
			req = REQ_ADVANCE;
		else
			req = REQ_NONE;
		send_req(req, pick_row(), random_row(), 1'b0, '0);
	endtask

	// Seed the board, run a few generations, then read every row back.
	task automatic run_pattern();
		int r, gens;
		r = eff_row_count();
		gens = $urandom_range(1, 4);
		for (int i = 0; i < r; i++)
			if ($urandom_range(0, 5) != 0)
				send_req(REQ_WRITE, IDX_IN_W'(i), random_row(), 1'b0, '0);
		for (int g = 0; g < gens; g++) begin
			// advance ignores index and bits; fill them anyway
			send_req(REQ_ADVANCE, IDX_IN_W'($urandom_range(0, 15)), random_row(), 1'b0, '0);
			if ($urandom_range(0, 2) == 0)
				send_req(REQ_READ, pick_row(), random_row(), 1'b0, '0);
		end
		for (int i = 0; i < r; i++)
			send_req(REQ_READ, IDX_IN_W'(i), random_row(), 1'b0, '0);
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	// Drop ready for random stretches; change only at the falling edge.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Compare each accepted word with the oldest owed one, field by field.
	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected word row_data=%h index_error=%b",
					row_data, index_error));
			end else begin
				want = pending_results.pop_front();
				if (row_data !== want.data)
					flag_error($sformatf("row_data expected %h got %h",
						want.data, row_data));
				if (index_error !== want.err)
					flag_error($sformatf("index_error expected %b got %b",
						want.err, index_error));
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words owed", cycle_cnt,
				pending_results.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin
		int phase_target;
		int phase;
		int rows, cols;

		clk        = 1'b0;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_ROWS;
		cfg_data   = '0;
		in_valid   = 1'b0;
		req_type   = REQ_WRITE;
		row_index  = '0;
		row_bits   = '0;
		out_ready  = 1'b0;
		stall_left = 0;
		no_idle    = 1'b0;
		cycle_cnt  = 0;
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		n_write = 0; n_read = 0; n_adv = 0; n_none = 0; n_bad = 0; n_cfg = 0;

		// Shadow starts where reset leaves the block: 11 rows, 38 columns, all dead.
		rows_cfg = ROWS_RESET;
		cols_cfg = COLS_RESET;
		for (int i = 0; i < DEF_MAX_ROWS; i++)
			life_board[i] = '0;

		// Directed table at the reset size. Typed rows carry their own expected
		// word; the rest rely on the predictor.
		dir_tab = '{
			// empty board after reset, then the row count boundary
			'{REQ_READ,    4'd0,  64'd0,                 1'b1, 64'd0, 1'b0},
			'{REQ_READ,    4'd15, 64'd0,                 1'b1, 64'd0, 1'b1},
			'{REQ_READ,    4'd11, 64'd0,                 1'b1, 64'd0, 1'b1},
			'{REQ_WRITE,   4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b1},
			// full row clipped to 38 columns
			'{REQ_WRITE,   4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b0},
			'{REQ_READ,    4'd0,  64'd0,                 1'b1, 64'h3F_FFFF_FFFF, 1'b0},
			// last row in use, top bit clipped
			'{REQ_WRITE,   4'd10, 64'h8000_0000_0000_0001, 1'b1, 64'd0, 1'b0},
			'{REQ_READ,    4'd10, 64'd0,                 1'b1, 64'd1, 1'b0},
			// unused request code
			'{REQ_NONE,    4'd3,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b0},
			// horizontal blinker turns vertical
			'{REQ_WRITE,   4'd0,  64'd0,                 1'b1, 64'd0, 1'b0},
			'{REQ_WRITE,   4'd5,  64'h70,                1'b1, 64'd0, 1'b0},
			'{REQ_ADVANCE, 4'd0,  64'd0,                 1'b1, 64'd0, 1'b0},
			'{REQ_READ,    4'd4,  64'd0,                 1'b0, 64'd0, 1'b0},
			'{REQ_READ,    4'd5,  64'd0,                 1'b0, 64'd0, 1'b0},
			'{REQ_READ,    4'd6,  64'd0,                 1'b0, 64'd0, 1'b0},
			// still block in the top corner
			'{REQ_WRITE,   4'd1,  64'h3,                 1'b1, 64'd0, 1'b0},
			'{REQ_WRITE,   4'd0,  64'h3,                 1'b1, 64'd0, 1'b0},
			'{REQ_ADVANCE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b0},
			'{REQ_READ,    4'd0,  64'd0,                 1'b0, 64'd0, 1'b0},
			'{REQ_READ,    4'd1,  64'd0,                 1'b0, 64'd0, 1'b0},
			// cells against the last column and the last row
			'{REQ_WRITE,   4'd10, 64'h60_0000_0000,      1'b1, 64'd0, 1'b0},
			'{REQ_WRITE,   4'd9,  64'h30_0000_0000,      1'b1, 64'd0, 1'b0},
			'{REQ_ADVANCE, 4'd0,  64'd0,                 1'b1, 64'd0, 1'b0},
			'{REQ_READ,    4'd9,  64'd0,                 1'b0, 64'd0, 1'b0},
			'{REQ_READ,    4'd10, 64'd0,                 1'b0, 64'd0, 1'b0}
		};

		// Hold reset for a few cycles, release it on a falling edge.
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the table with no idling so words go back to back.
		no_idle = 1'b1;
		for (int k = 0; k < DIR_N; k++)
			send_req(dir_tab[k].req, dir_tab[k].idx, dir_tab[k].bits, dir_tab[k].typed,
				row_result_t'({dir_tab[k].data, dir_tab[k].err}));

		// Random phases: fixed sizes first (extremes among them), then random sizes.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0:       begin rows = 16; cols = 64; end
				1:       begin rows = 1;  cols = 1;  end
				2:       begin rows = 16; cols = 1;  end
				3:       begin rows = 1;  cols = 64; end
				4:       begin rows = 3;  cols = 3;  end
				5:       begin rows = 2;  cols = 2;  end
				6:       begin rows = 16; cols = 63; end
				7:       begin rows = 15; cols = 33; end
				default: begin rows = $urandom_range(1, 16); cols = $urandom_range(1, 64); end
			endcase
			set_board_size(rows, cols);
			// Some phases run flat out on both sides.
			no_idle = ($urandom_range(0, 3) == 0);
			phase_target = items_sent + 120;
			while (items_sent < phase_target) begin
				if ($urandom_range(0, 99) < 60)
					run_pattern();
				else
					repeat ($urandom_range(1, 8)) random_request();
				// Hold the sender now and then until the block has caught up.
				if ($urandom_range(0, 19) == 0)
					drain();
			end
			phase++;
		end

		// Return to the reset size once so that setting is used after other sizes too.
		set_board_size(ROWS_RESET, COLS_RESET);
		no_idle = 1'b0;
		repeat (40) random_request();

		drain();
		$display("summary: %0d requests: %0d writes, %0d reads, %0d advances, %0d unused codes",
			items_sent, n_write, n_read, n_adv, n_none);
		$display("summary: %0d bad rows, %0d board sizes, %0d words checked, %0d mismatches",
			n_bad, n_cfg, results_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_row_cell.sv
hw/rtl/lgs_rule.sv
hw/rtl/life_grid_generation_step.sv
tb/tb_top.sv
